### hdl/window_lift_controller_unit_assert.svh
// Assertion macros for the window lift controller modules.
// They expect i_clk and i_rst_n in the module that uses them.
`ifndef WINDOW_LIFT_CONTROLLER_UNIT_ASSERT_SVH
`define WINDOW_LIFT_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define WLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WLC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define WLC_ASSERT(label, prop, msg)
`define WLC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

### hdl/wlc_pkg.sv
package wlc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    // Wide enough to compare the counter against a register at widths up to 33 bits.
    localparam int CMP_W       = 33;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_W-1:0] HOLD_TICKS_RESET    = CFG_W'(1000);
    localparam logic [CFG_W-1:0] REVERSE_TICKS_RESET = CFG_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS = CFG_IDX_W'(1);

    localparam logic [1:0] BTN_DRV_OPEN   = 2'd0;
    localparam logic [1:0] BTN_DRV_CLOSE  = 2'd1;
    localparam logic [1:0] BTN_PASS_OPEN  = 2'd2;
    localparam logic [1:0] BTN_PASS_CLOSE = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_DECIDE = 3'd1,
        MODE_MANUAL = 3'd2,
        MODE_AUTO   = 3'd3,
        MODE_JAM    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] reverse_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] btn;          // indexed by the BTN_* codes
        logic       open_end;
        logic       close_end;
        logic       jam_level;
        logic       lock_on;
    } t_item;

    typedef struct packed {
        logic  motor_open;
        logic  motor_close;
        logic  lock_indicator;
        t_mode mode;
    } t_result;

endpackage

### hdl/wlc_cfg_regs.sv
module wlc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [wlc_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [wlc_pkg::CFG_W-1:0]      i_data,
    output wlc_pkg::t_cfg                  o_cfg
);
    import wlc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks    <= HOLD_TICKS_RESET;
            r_cfg.reverse_ticks <= REVERSE_TICKS_RESET;
        end else if (i_wr_en) begin
            // Writes to indexes outside the register list are dropped.
            unique case (i_index)
                CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_data;
                CFG_REVERSE_TICKS: r_cfg.reverse_ticks <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/wlc_ctrl_core.sv
`include "window_lift_controller_unit_assert.svh"

module wlc_ctrl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  wlc_pkg::t_item   i_item,
    input  wlc_pkg::t_cfg    i_cfg,
    output wlc_pkg::t_result o_res
);
    import wlc_pkg::*;

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_btn, n_btn;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_jam_prev;

    logic                   jam_fall;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CFG_W-1:0]       limit;
    logic                   expired;
    logic                   auto_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_btn      <= BTN_DRV_OPEN;
            r_cnt      <= '0;
            r_jam_prev <= 1'b1;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_btn      <= n_btn;
            r_cnt      <= n_cnt;
            r_jam_prev <= i_item.jam_level;
        end
    end

    assign jam_fall = r_jam_prev && !i_item.jam_level;
    assign cnt_inc  = (r_cnt != CNT_MAX) ? r_cnt + COUNT_WIDTH'(1) : r_cnt;
    assign limit    = (r_mode == MODE_JAM) ? i_cfg.reverse_ticks : i_cfg.hold_ticks;
    // A saturated counter counts as expired even when the limit lies beyond it.
    assign expired  = ({{(CMP_W-COUNT_WIDTH){1'b0}}, cnt_inc}
                       >= {{(CMP_W-CFG_W){1'b0}}, limit}) || (cnt_inc == CNT_MAX);
    // Even codes open, odd codes close; the seat's other button is the code with bit 0 flipped.
    assign auto_stop = (r_btn[0] ? i_item.close_end : i_item.open_end)
                       || i_item.btn[r_btn] || i_item.btn[r_btn ^ 2'd1];

    always_comb begin
        n_mode = r_mode;
        n_btn  = r_btn;
        n_cnt  = r_cnt;
        if (jam_fall) begin
            n_mode = MODE_JAM;
            n_cnt  = '0;
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    priority if (i_item.btn[BTN_DRV_OPEN]) begin
                        n_mode = MODE_DECIDE;
                        n_btn  = BTN_DRV_OPEN;
                        n_cnt  = '0;
                    end else if (i_item.btn[BTN_DRV_CLOSE]) begin
                        n_mode = MODE_DECIDE;
                        n_btn  = BTN_DRV_CLOSE;
                        n_cnt  = '0;
                    end else if (!i_item.lock_on && i_item.btn[BTN_PASS_OPEN]) begin
                        n_mode = MODE_DECIDE;
                        n_btn  = BTN_PASS_OPEN;
                        n_cnt  = '0;
                    end else if (!i_item.lock_on && i_item.btn[BTN_PASS_CLOSE]) begin
                        n_mode = MODE_DECIDE;
                        n_btn  = BTN_PASS_CLOSE;
                        n_cnt  = '0;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_DECIDE: begin
                    n_cnt = cnt_inc;
                    if (expired) begin
                        priority if (i_item.btn[r_btn]) n_mode = MODE_MANUAL;
                        else if (auto_stop)             n_mode = MODE_IDLE;
                        else                            n_mode = MODE_AUTO;
                    end
                end
                MODE_MANUAL: begin
                    if (!i_item.btn[r_btn]) n_mode = MODE_IDLE;
                end
                MODE_AUTO: begin
                    if (auto_stop) n_mode = MODE_IDLE;
                end
                MODE_JAM: begin
                    n_cnt = cnt_inc;
                    if (expired) n_mode = MODE_IDLE;
                end
                default: n_mode = MODE_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res.mode           = n_mode;
        o_res.lock_indicator = i_item.lock_on;
        o_res.motor_open     = (n_mode == MODE_JAM) || (n_mode != MODE_IDLE && !n_btn[0]);
        o_res.motor_close    = (n_mode != MODE_JAM) && (n_mode != MODE_IDLE) && n_btn[0];
    end

    `WLC_ASSERT_NEVER(a_motor_both, o_res.motor_open && o_res.motor_close, "motor driven both ways")
    `WLC_ASSERT(a_jam_enter, i_step && jam_fall |=> r_mode == MODE_JAM, "jam edge missed")
    `WLC_ASSERT(a_hold_state, !i_step |=> $stable(r_mode) && $stable(r_cnt) && $stable(r_btn), "state moved without a tick")
    `WLC_ASSERT(a_manual_exit, i_step && r_mode == MODE_MANUAL && !jam_fall |-> n_mode == MODE_MANUAL || n_mode == MODE_IDLE, "bad exit from manual motion")

endmodule

### hdl/window_lift_controller_unit.sv
// A result passes the input register and then the result register before it is valid.
// Throughput: one input transaction per cycle while results are taken; each tick is one pass of the mode logic.
// A waiting result blocks input once the input register also holds a transaction.
// Reset (synchronous, active low) sets the mode to idle, clears the counter, marks the jam line high
// and loads 1000 into both timing registers; the block is ready for transactions once reset is released.
module window_lift_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_drv_open_pressed,
    input  logic                          i_drv_close_pressed,
    input  logic                          i_pass_open_pressed,
    input  logic                          i_pass_close_pressed,
    input  logic                          i_open_end_reached,
    input  logic                          i_close_end_reached,
    input  logic                          i_jam_level,
    input  logic                          i_lock_on,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_motor_open,
    output logic                          o_motor_close,
    output logic                          o_lock_indicator,
    output logic [2:0]                    o_mode,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wlc_pkg::CFG_W-1:0]     i_cfg_data
);
    import wlc_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;

    logic    adv;
    t_cfg    cfg;
    t_result res;

    assign o_cfg_ready = 1'b1;

    wlc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The held item moves on when the result register is free or being emptied.
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.btn       <= {i_pass_close_pressed, i_pass_open_pressed,
                                 i_drv_close_pressed, i_drv_open_pressed};
            r_item.open_end  <= i_open_end_reached;
            r_item.close_end <= i_close_end_reached;
            r_item.jam_level <= i_jam_level;
            r_item.lock_on   <= i_lock_on;
        end
    end

    wlc_ctrl_core u_ctrl_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_motor_open     = r_res.motor_open;
    assign o_motor_close    = r_res.motor_close;
    assign o_lock_indicator = r_res.lock_indicator;
    assign o_mode           = r_res.mode;

endmodule

### test/window_lift_checker.sv
`timescale 1ns / 100ps

module window_lift_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_drv_open_pressed,
    input  logic                          i_drv_close_pressed,
    input  logic                          i_pass_open_pressed,
    input  logic                          i_pass_close_pressed,
    input  logic                          i_open_end_reached,
    input  logic                          i_close_end_reached,
    input  logic                          i_jam_level,
    input  logic                          i_lock_on,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_motor_open,
    input  logic                          i_motor_close,
    input  logic                          i_lock_indicator,
    input  logic [2:0]                    i_mode,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [wlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wlc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    import wlc_pkg::*;

    logic [CFG_W-1:0]       hold_lim;
    logic [CFG_W-1:0]       rev_lim;
    t_mode                  mode_now;
    logic [1:0]             btn_sel;
    logic [COUNT_WIDTH-1:0] ticks;
    logic                   jam_last;
    t_result                drive_expected[$];
    int                     fails;

    // The counter saturates, and reaching its top counts as expiry.
    function automatic logic tick_elapsed(input logic [CFG_W-1:0] limit);
        if (ticks != CNT_MAX) begin
            ticks = ticks + 1'b1;
        end
        return (ticks >= limit) || (ticks == CNT_MAX);
    endfunction

    function automatic logic auto_done(input t_item it);
        logic limit_hit;
        limit_hit = btn_sel[0] ? it.close_end : it.open_end;
        return limit_hit || it.btn[btn_sel] || it.btn[btn_sel ^ 2'd1];
    endfunction

    function automatic t_result predict_window_tick(input t_item it);
        t_result r;
        logic    started;
        int      b;
        started = 1'b0;
        if (jam_last && !it.jam_level) begin
            mode_now = MODE_JAM;
            ticks    = '0;
        end else begin
            case (mode_now)
                MODE_IDLE: begin
                    // Lower index wins; the lock only masks the passenger seat.
                    for (b = 0; b < 4 && !started; b++) begin
                        if (it.btn[b[1:0]] && !(b >= 2 && it.lock_on)) begin
                            mode_now = MODE_DECIDE;
                            btn_sel  = b[1:0];
                            ticks    = '0;
                            started  = 1'b1;
                        end
                    end
                end
                MODE_DECIDE: begin
                    if (tick_elapsed(hold_lim)) begin
                        if (it.btn[btn_sel]) begin
                            mode_now = MODE_MANUAL;
                        end else if (auto_done(it)) begin
                            mode_now = MODE_IDLE;
                        end else begin
                            mode_now = MODE_AUTO;
                        end
                    end
                end
                MODE_MANUAL: begin
                    if (!it.btn[btn_sel]) begin
                        mode_now = MODE_IDLE;
                    end
                end
                MODE_AUTO: begin
                    if (auto_done(it)) begin
                        mode_now = MODE_IDLE;
                    end
                end
                MODE_JAM: begin
                    if (tick_elapsed(rev_lim)) begin
                        mode_now = MODE_IDLE;
                    end
                end
                default: begin
                    mode_now = MODE_IDLE;
                end
            endcase
        end
        jam_last = it.jam_level;

        r.motor_open     = (mode_now == MODE_JAM) ||
                           (mode_now != MODE_IDLE && !btn_sel[0]);
        r.motor_close    = (mode_now != MODE_JAM) && (mode_now != MODE_IDLE) && btn_sel[0];
        r.lock_indicator = it.lock_on;
        r.mode           = mode_now;
        return r;
    endfunction

    task automatic flag(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            hold_lim = HOLD_TICKS_RESET;
            rev_lim  = REVERSE_TICKS_RESET;
            mode_now = MODE_IDLE;
            btn_sel  = BTN_DRV_OPEN;
            ticks    = '0;
            jam_last = 1'b1;
            fails    = 0;
            drive_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.motor_open     = i_motor_open;
                got.motor_close    = i_motor_close;
                got.lock_indicator = i_lock_indicator;
                got.mode           = t_mode'(i_mode);
                if (drive_expected.size() == 0) begin
                    flag($sformatf("result transaction with nothing expected: mode %0d", i_mode));
                end else begin
                    want = drive_expected.pop_front();
                    if (got.motor_open !== want.motor_open ||
                        got.motor_close !== want.motor_close ||
                        got.lock_indicator !== want.lock_indicator ||
                        got.mode !== want.mode) begin
                        flag($sformatf({"mismatch: expected open %0b close %0b lamp %0b mode %0d,",
                                        " got open %0b close %0b lamp %0b mode %0d"},
                                       want.motor_open, want.motor_close,
                                       want.lock_indicator, want.mode,
                                       got.motor_open, got.motor_close,
                                       got.lock_indicator, i_mode));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HOLD_TICKS:    hold_lim = i_cfg_data;
                    CFG_REVERSE_TICKS: rev_lim  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                it.btn[BTN_DRV_OPEN]   = i_drv_open_pressed;
                it.btn[BTN_DRV_CLOSE]  = i_drv_close_pressed;
                it.btn[BTN_PASS_OPEN]  = i_pass_open_pressed;
                it.btn[BTN_PASS_CLOSE] = i_pass_close_pressed;
                it.open_end            = i_open_end_reached;
                it.close_end           = i_close_end_reached;
                it.jam_level           = i_jam_level;
                it.lock_on             = i_lock_on;
                drive_expected.push_back(predict_window_tick(it));
            end
        end
        o_pending    <= drive_expected.size();
        o_fail_count <= fails;
    end

endmodule

### test/window_lift_controller_unit_test.sv
`timescale 1ns / 100ps

module window_lift_controller_unit_test;
    import wlc_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_item                tick_in   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 motor_open;
    logic                 motor_close;
    logic                 lock_lamp;
    logic [2:0]           mode;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HOLD_TICKS;
    logic [CFG_W-1:0]     cfg_data  = '0;
    int                   pending;
    int                   fail_count;
    logic                 calm         = 1'b0;
    int                   hold_now     = 1000;
    int                   rev_now      = 1000;
    int                   sent         = 0;
    int                   quiet_cycles = 0;

    window_lift_controller_unit dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_drv_open_pressed   (tick_in.btn[BTN_DRV_OPEN]),
        .i_drv_close_pressed  (tick_in.btn[BTN_DRV_CLOSE]),
        .i_pass_open_pressed  (tick_in.btn[BTN_PASS_OPEN]),
        .i_pass_close_pressed (tick_in.btn[BTN_PASS_CLOSE]),
        .i_open_end_reached   (tick_in.open_end),
        .i_close_end_reached  (tick_in.close_end),
        .i_jam_level          (tick_in.jam_level),
        .i_lock_on            (tick_in.lock_on),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_motor_open         (motor_open),
        .o_motor_close        (motor_close),
        .o_lock_indicator     (lock_lamp),
        .o_mode               (mode),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    window_lift_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_drv_open_pressed   (tick_in.btn[BTN_DRV_OPEN]),
        .i_drv_close_pressed  (tick_in.btn[BTN_DRV_CLOSE]),
        .i_pass_open_pressed  (tick_in.btn[BTN_PASS_OPEN]),
        .i_pass_close_pressed (tick_in.btn[BTN_PASS_CLOSE]),
        .i_open_end_reached   (tick_in.open_end),
        .i_close_end_reached  (tick_in.close_end),
        .i_jam_level          (tick_in.jam_level),
        .i_lock_on            (tick_in.lock_on),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_motor_open         (motor_open),
        .i_motor_close        (motor_close),
        .i_lock_indicator     (lock_lamp),
        .i_mode               (mode),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .o_pending            (pending),
        .o_fail_count         (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("window_lift_controller_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_item mk(input logic [3:0] btn, input logic open_end,
                                 input logic close_end, input logic jam, input logic lock);
        t_item it;
        it.btn       = btn;
        it.open_end  = open_end;
        it.close_end = close_end;
        it.jam_level = jam;
        it.lock_on   = lock;
        return it;
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [3:0] stray_buttons();
        return {chance(3), chance(3), chance(3), chance(3)};
    endfunction

    task automatic send_tick(input t_item it);
        if (!calm && chance(7)) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (chance(7));
        end
        in_valid <= 1'b1;
        tick_in  <= it;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Drop valid and let every outstanding result drain before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HOLD_TICKS) begin
            hold_now = int'(val);
        end else begin
            rev_now = int'(val);
        end
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] rev);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_REVERSE_TICKS, rev);
    endtask

    // One press with random content, a coasting stretch and one of four ways of ending it, or none.
    task automatic press_episode();
        int         b;
        int         k;
        int         held;
        int         coast;
        logic       lock;
        logic [3:0] btn;
        b     = $urandom_range(3);
        lock  = chance(12);
        held  = $urandom_range(1, hold_now + 3);
        coast = $urandom_range(0, 10);
        btn   = '0;
        btn[b[1:0]] = 1'b1;
        for (k = 0; k < held; k++) begin
            send_tick(mk(btn | stray_buttons(), chance(5), chance(5), 1'b1, lock));
        end
        for (k = 0; k < coast; k++) begin
            send_tick(mk(stray_buttons(), chance(3), chance(3), 1'b1, lock ^ chance(3)));
        end
        case ($urandom_range(4))
            0: send_tick(mk('0, !b[0], b[0], 1'b1, lock));
            1: send_tick(mk(btn, 1'b0, 1'b0, 1'b1, lock));
            2: begin
                btn = '0;
                btn[b[1:0] ^ 2'd1] = 1'b1;
                send_tick(mk(btn, 1'b0, 1'b0, 1'b1, lock));
            end
            3: begin
                // Jam pulse; buttons keep changing while the window backs off.
                send_tick(mk(stray_buttons(), 1'b0, 1'b0, 1'b0, lock));
                for (k = 0; k <= rev_now + 1; k++) begin
                    send_tick(mk(4'($urandom_range(15)), chance(5), chance(5), !chance(4),
                                 lock));
                end
            end
            default: ;
        endcase
        send_tick(mk('0, 1'b0, 1'b0, 1'b1, lock));
    endtask

    task automatic noise_episode();
        int k;
        int len;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
            send_tick(mk(4'($urandom_range(15)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1))));
        end
    endtask

    task automatic random_phase(input int count);
        int first;
        first = sent;
        while (sent - first < count) begin
            if ($urandom_range(4) == 0) begin
                noise_episode();
            end else begin
                press_episode();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_timing(16'd2, 16'd3);
        // Jam from reset, a restart during the reverse, then the reverse runs out.
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk(4'b0001, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (3) send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        // All buttons at once: the driver open button wins. Manual ignores limits.
        send_tick(mk(4'b1111, 1'b1, 1'b1, 1'b1, 1'b1));
        repeat (2) send_tick(mk(4'b0001, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(mk(4'b0001, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        // Lock blocks the passenger seat; unlocked, passenger open runs to its end.
        send_tick(mk(4'b1100, 1'b0, 1'b0, 1'b1, 1'b1));
        send_tick(mk(4'b1100, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (3) send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b1, 1'b0, 1'b1, 1'b0));
        // Close end already reached when the press is judged.
        send_tick(mk(4'b0010, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b1, 1'b1, 1'b0));
        // Same button again stops; still held, it starts over on the next tick.
        send_tick(mk(4'b1000, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (2) send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (2) send_tick(mk(4'b1000, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (2) send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0100, 1'b0, 1'b0, 1'b1, 1'b0));

        // Zero timing registers act as a single elapsed tick.
        set_timing(16'd0, 16'd0);
        repeat (2) send_tick(mk(4'b0010, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0100, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));

        // Largest settings: a long decision is cut short by a jam, and the reverse
        // ends once a small reverse time is loaded below the count already reached.
        set_timing(16'hFFFF, 16'hFFFF);
        calm <= 1'b1;
        repeat (20) send_tick(mk(4'b0010, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (20) send_tick(mk(4'b0000, 1'b0, 1'b0, 1'b1, 1'b0));
        calm <= 1'b0;

        set_timing(16'd1, 16'd1);
        random_phase(200);
        set_timing(16'd4, 16'd6);
        calm <= 1'b1;
        random_phase(200);
        calm <= 1'b0;
        set_timing(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 24)));
        random_phase(200);
        set_timing(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 24)));
        random_phase(200);
        set_timing(16'd7, 16'd2);
        random_phase(200);

        settle();
        if (fail_count == 0) begin
            $display("window_lift_controller_unit regression: pass");
        end else begin
            $display("window_lift_controller_unit regression: fail");
        end
        $finish;
    end

endmodule
